// File: design/adcapl_pkg.sv
// ----------------------------------------------------------------------------
// adcapl_pkg
// Shared types, widths, status codes and breakpoint tables for the ADC
// averaging and piecewise-linear conversion block.
// ----------------------------------------------------------------------------
package adcapl_pkg;

  // Field widths fixed by the interface.
  localparam int SMP_W    = 12;
  localparam int SUM_W    = 16;
  localparam int CNT_W    = 4;
  localparam int VALUE_W  = 14;
  localparam int STATUS_W = 2;
  localparam int LIM_W    = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_AW   = 1;

  // Defaults for the top-level parameters.
  localparam int AVG_SAMPLES_DEF = 10;
  localparam int FRAC_BITS_DEF   = 8;

  // Reset values of the limit registers.
  localparam logic [LIM_W-1:0] UNDER_LIMIT_RST = 12'd535;
  localparam logic [LIM_W-1:0] OVER_LIMIT_RST  = 12'd3685;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_UNDER_LIMIT = 1'b0;
  localparam logic [CFG_AW-1:0] REG_OVER_LIMIT  = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;

  // Breakpoint table geometry.
  localparam int TABLE_POINTS = 17;
  localparam int PT_W   = $clog2(TABLE_POINTS);
  localparam int BPI_W  = 12;             // input breakpoints, unsigned
  localparam int BPO_W  = 8;              // output breakpoints, signed
  localparam int DIFF_W = BPI_W + 1;      // mean minus breakpoint, signed
  localparam int DOUT_W = BPO_W + 1;      // output step, signed
  localparam int PROD_W = DIFF_W + DOUT_W;

  localparam logic [BPI_W-1:0] BP_IN [TABLE_POINTS] = '{
    12'd739,  12'd925,  12'd1110, 12'd1295, 12'd1481, 12'd1666,
    12'd1851, 12'd2037, 12'd2222, 12'd2407, 12'd2593, 12'd2779,
    12'd2963, 12'd3149, 12'd3335, 12'd3520, 12'd3703
  };

  localparam logic signed [BPO_W-1:0] BP_OUT [TABLE_POINTS] = '{
    8'sd0,  8'sd1,  8'sd2,  8'sd3,  8'sd4,  8'sd5,  8'sd6,  8'sd7,  8'sd8,
    8'sd9,  8'sd10, 8'sd11, 8'sd12, 8'sd13, 8'sd14, 8'sd15, 8'sd16
  };

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_ACC,
    ST_MEAN,
    ST_CHECK,
    ST_SEEK,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// File: design/adcapl_sdiv.sv
// ----------------------------------------------------------------------------
// adcapl_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module adcapl_sdiv #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int DCNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    trial_sub;
  logic              fits;

  // One trial subtraction per cycle; the dividend shifts out as the
  // quotient shifts in.
  always_comb begin
    trial     = {rem_r, quo_r[DVD_W-1]};
    trial_sub = trial - {1'b0, divisor};
    fits      = (trial >= {1'b0, divisor});
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DCNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      rem_nxt = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the data path is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/adc_average_piecewise_linearize.sv
// ----------------------------------------------------------------------------
// adc_average_piecewise_linearize
// Averages groups of 12-bit ADC samples from a 4-20 mA loop and converts
// each mean through a breakpoint table into a fixed-point measurement.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive as words on the in_ channel (sample in in_tdata[11:0]).
//   Every AVG_SAMPLES accepted words produce one result word on the out_
//   channel: value in out_tdata[13:0], status in out_tuser.
//   Words that do not close a group are taken one per cycle. The word that
//   closes a group starts the conversion and in_tready stays low until the
//   result is loaded: bit-serial mean division and a limit check, after which
//   an out-of-range mean is loaded. An in-range mean adds a segment search,
//   the forming of the numerator and the bit-serial division of it by the
//   segment width.
//   The result sits in an output register, so sampling resumes while it waits
//   to be taken; a second result waits in the sequencer if the first is
//   still stalled by out_tready.
//   The limit registers are written through cfg_we, cfg_addr and cfg_wdata
//   while the block is idle. Reset (rst_n low) clears the running sum and
//   count, drops out_tvalid and restores the limits to 535 and 3685.
// ----------------------------------------------------------------------------
module adc_average_piecewise_linearize #(
  parameter int AVG_SAMPLES = adcapl_pkg::AVG_SAMPLES_DEF,
  parameter int FRAC_BITS   = adcapl_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream: [11:0] sample, [15:12] ignored.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [adcapl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Output stream: [13:0] value, [15:14] zero.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [adcapl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Output sideband: [1:0] status.
  output logic [adcapl_pkg::STATUS_W-1:0]      out_tuser,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [adcapl_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [adcapl_pkg::LIM_W-1:0]         cfg_wdata
);

  localparam int AVG_W  = $clog2(AVG_SAMPLES + 1);
  localparam int NUM_W  = adcapl_pkg::PROD_W + FRAC_BITS;
  localparam int VAL_W  = NUM_W + 1;
  localparam int SMP_W  = adcapl_pkg::SMP_W;
  localparam int SUM_W  = adcapl_pkg::SUM_W;
  localparam int CNT_W  = adcapl_pkg::CNT_W;
  localparam int PT_W   = adcapl_pkg::PT_W;
  localparam int BPI_W  = adcapl_pkg::BPI_W;
  localparam int DIFF_W = adcapl_pkg::DIFF_W;
  localparam int DOUT_W = adcapl_pkg::DOUT_W;
  localparam int PROD_W = adcapl_pkg::PROD_W;
  localparam int LIM_W  = adcapl_pkg::LIM_W;
  localparam int VALUE_W = adcapl_pkg::VALUE_W;
  localparam int STATUS_W = adcapl_pkg::STATUS_W;

  adcapl_pkg::state_t state_r, state_nxt;

  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [LIM_W-1:0]          under_r, under_nxt;
  logic [LIM_W-1:0]          over_r, over_nxt;
  logic [SMP_W-1:0]          mean_r, mean_nxt;
  logic [PT_W-1:0]           seg_r, seg_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [BPI_W-1:0]          den_r, den_nxt;
  logic                      den_neg_r, den_neg_nxt;
  logic                      den_zero_r, den_zero_nxt;
  logic                      qneg_r, qneg_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [VALUE_W-1:0]        out_value_r, out_value_nxt;
  logic [STATUS_W-1:0]       out_tuser_r, out_tuser_nxt;

  logic                      in_acc;
  logic [SUM_W-1:0]          sum_add;
  logic [CNT_W:0]            cnt_inc;
  logic                      grp_last;
  logic                      mean_start, mean_done;
  logic [SUM_W-1:0]          mean_q;
  logic                      div_start, div_done;
  logic [NUM_W-1:0]          div_q;
  logic [PT_W-1:0]           seg_p1;
  logic                      seg_step;
  logic signed [DIFF_W-1:0]  diff_s;
  logic signed [DOUT_W-1:0]  dout_s;
  logic signed [DIFF_W-1:0]  den_s;
  logic signed [NUM_W-1:0]   num_ext;
  logic signed [NUM_W-1:0]   num_s;
  logic [NUM_W-1:0]          num_mag;
  logic signed [VAL_W-1:0]   base_s;
  logic signed [VAL_W-1:0]   quo_s;
  logic signed [VAL_W-1:0]   val_s;
  logic                      out_free;
  logic                      out_load;

  // Handshake and group bookkeeping.
  assign in_acc   = in_tvalid & in_tready;
  assign sum_add  = sum_r + SUM_W'(in_tdata[SMP_W-1:0]);
  assign cnt_inc  = {1'b0, cnt_r} + (CNT_W + 1)'(1);
  assign grp_last = !(cnt_inc < (CNT_W + 1)'(AVG_SAMPLES));
  assign out_free = !out_tvalid_r || out_tready;

  // Mean divider: running sum over the group size.
  adcapl_sdiv #(
    .DVD_W (SUM_W),
    .DVS_W (AVG_W)
  ) u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mean_start),
    .dividend (sum_add),
    .divisor  (AVG_W'(AVG_SAMPLES)),
    .done     (mean_done),
    .quotient (mean_q)
  );

  // Interpolation divider: numerator magnitude over the segment width.
  adcapl_sdiv #(
    .DVD_W (NUM_W),
    .DVS_W (BPI_W)
  ) u_interp_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Segment search and interpolation arithmetic.
  always_comb begin
    seg_p1   = seg_r + PT_W'(1);
    seg_step = (seg_r < PT_W'(adcapl_pkg::TABLE_POINTS - 2)) &&
               (adcapl_pkg::BP_IN[seg_p1] < mean_r);
    diff_s   = $signed({1'b0, mean_r}) - $signed({1'b0, adcapl_pkg::BP_IN[seg_r]});
    dout_s   = DOUT_W'(adcapl_pkg::BP_OUT[seg_p1]) - DOUT_W'(adcapl_pkg::BP_OUT[seg_r]);
    den_s    = $signed({1'b0, adcapl_pkg::BP_IN[seg_p1]}) -
               $signed({1'b0, adcapl_pkg::BP_IN[seg_r]});
    num_ext  = NUM_W'(prod_r);
    num_s    = num_ext <<< FRAC_BITS;
    num_mag  = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    base_s   = VAL_W'(adcapl_pkg::BP_OUT[seg_r]) <<< FRAC_BITS;
    quo_s    = qneg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    val_s    = den_zero_r ? base_s : (base_s + quo_s);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      adcapl_pkg::ST_ACC: begin
        if (in_acc && grp_last) state_nxt = adcapl_pkg::ST_MEAN;
      end
      adcapl_pkg::ST_MEAN: begin
        if (mean_done) state_nxt = adcapl_pkg::ST_CHECK;
      end
      adcapl_pkg::ST_CHECK: begin
        if ((mean_r < under_r) || (mean_r > over_r)) state_nxt = adcapl_pkg::ST_EMIT;
        else state_nxt = adcapl_pkg::ST_SEEK;
      end
      adcapl_pkg::ST_SEEK: begin
        if (!seg_step) state_nxt = adcapl_pkg::ST_MUL;
      end
      adcapl_pkg::ST_MUL:  state_nxt = adcapl_pkg::ST_LOAD;
      adcapl_pkg::ST_LOAD: state_nxt = adcapl_pkg::ST_DIV;
      adcapl_pkg::ST_DIV: begin
        if (div_done) state_nxt = adcapl_pkg::ST_EMIT;
      end
      adcapl_pkg::ST_EMIT: begin
        if (out_free) state_nxt = adcapl_pkg::ST_ACC;
      end
      default: state_nxt = adcapl_pkg::ST_ACC;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready  = 1'b0;
    mean_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      adcapl_pkg::ST_ACC: begin
        in_tready  = 1'b1;
        mean_start = in_tvalid && grp_last;
      end
      adcapl_pkg::ST_LOAD: div_start = 1'b1;
      adcapl_pkg::ST_EMIT: out_load  = out_free;
      default: ;
    endcase
  end

  // Data path and register next values.
  always_comb begin
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    under_nxt    = under_r;
    over_nxt     = over_r;
    mean_nxt     = mean_r;
    seg_nxt      = seg_r;
    status_nxt   = status_r;
    prod_nxt     = prod_r;
    den_nxt      = den_r;
    den_neg_nxt  = den_neg_r;
    den_zero_nxt = den_zero_r;
    qneg_nxt     = qneg_r;
    out_value_nxt = out_value_r;
    out_tuser_nxt = out_tuser_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;

    // Limit registers.
    if (cfg_we) begin
      case (cfg_addr)
        adcapl_pkg::REG_UNDER_LIMIT: under_nxt = cfg_wdata;
        adcapl_pkg::REG_OVER_LIMIT:  over_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    // Accumulate; the closing word clears the group.
    if (in_acc) begin
      if (grp_last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_inc[CNT_W-1:0];
      end
    end

    if (mean_done) mean_nxt = mean_q[SMP_W-1:0];

    // Range check; under-range wins when both limits are violated.
    if (state_r == adcapl_pkg::ST_CHECK) begin
      seg_nxt = '0;
      if (mean_r < under_r) status_nxt = adcapl_pkg::STATUS_UNDER;
      else if (mean_r > over_r) status_nxt = adcapl_pkg::STATUS_OVER;
      else status_nxt = adcapl_pkg::STATUS_OK;
    end

    if ((state_r == adcapl_pkg::ST_SEEK) && seg_step) seg_nxt = seg_p1;

    // Segment found: form the product and the segment width.
    if (state_r == adcapl_pkg::ST_MUL) begin
      prod_nxt     = diff_s * dout_s;
      den_neg_nxt  = den_s[DIFF_W-1];
      den_zero_nxt = (den_s == '0);
      den_nxt      = den_s[DIFF_W-1] ? BPI_W'(-den_s) : BPI_W'(den_s);
    end

    // Quotient sign follows truncation toward zero.
    if (state_r == adcapl_pkg::ST_LOAD) qneg_nxt = num_s[NUM_W-1] ^ den_neg_r;

    // Hand the result to the output register.
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tuser_nxt  = status_r;
      out_value_nxt  = (status_r == adcapl_pkg::STATUS_OK) ? val_s[VALUE_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= adcapl_pkg::ST_ACC;
      sum_r        <= '0;
      cnt_r        <= '0;
      under_r      <= adcapl_pkg::UNDER_LIMIT_RST;
      over_r       <= adcapl_pkg::OVER_LIMIT_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      under_r      <= under_nxt;
      over_r       <= over_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    mean_r      <= mean_nxt;
    seg_r       <= seg_nxt;
    status_r    <= status_nxt;
    prod_r      <= prod_nxt;
    den_r       <= den_nxt;
    den_neg_r   <= den_neg_nxt;
    den_zero_r  <= den_zero_nxt;
    qneg_r      <= qneg_nxt;
    out_value_r <= out_value_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = adcapl_pkg::OUT_TDATA_W'(out_value_r);
  assign out_tuser  = out_tuser_r;

endmodule

// File: tb/adc_average_piecewise_linearize_test.sv
// ----------------------------------------------------------------------------
// adc_average_piecewise_linearize_test
// Self-checking bench for the ADC averaging and linearisation block. Sample
// words are streamed in with random gaps, and an in-bench model predicts
// each averaged reading. Every result word taken from the output stream is
// compared with the oldest prediction. The limit registers are moved
// through reset, full-scale, crossed, equal and random settings.
// ----------------------------------------------------------------------------
module adc_average_piecewise_linearize_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PERCENT = 36;
  localparam int TAIL_CYCLES  = 80;

  // One predicted reading: interpolated value and range status.
  typedef struct packed {
    logic signed [adcapl_pkg::VALUE_W-1:0] value;
    logic [adcapl_pkg::STATUS_W-1:0]       status;
  } reading_t;

  logic                               clk;
  logic                               rst_n      = 1'b0;
  logic                               in_tvalid  = 1'b0;
  logic                               in_tready;
  logic [adcapl_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [adcapl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [adcapl_pkg::STATUS_W-1:0]    out_tuser;
  logic                               cfg_we     = 1'b0;
  logic [adcapl_pkg::CFG_AW-1:0]      cfg_addr   = '0;
  logic [adcapl_pkg::LIM_W-1:0]       cfg_wdata  = '0;

  // Model state: limits, running sum and count of the current group.
  logic [adcapl_pkg::LIM_W-1:0] under_lim   = adcapl_pkg::UNDER_LIMIT_RST;
  logic [adcapl_pkg::LIM_W-1:0] over_lim    = adcapl_pkg::OVER_LIMIT_RST;
  logic [adcapl_pkg::SUM_W-1:0] accum_sum   = '0;
  int                           accum_count = 0;

  reading_t pending_readings[$];

  bit quiet       = 1'b0;
  int errors      = 0;
  int cycle_count = 0;
  int samples_in  = 0;
  int n_ok        = 0;
  int n_under     = 0;
  int n_over      = 0;
  int n_settings  = 1;

  adc_average_piecewise_linearize dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d readings outstanding",
               cycle_count, pending_readings.size());
      $display("adc_average_piecewise_linearize_test: FAIL");
      $finish;
    end
  end

  // Output back-pressure, off during the quiet stretch.
  always @(negedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Converts a group mean into the expected reading.
  function automatic reading_t convert_mean(input int mean);
    reading_t r;
    int seg;
    int den;
    int num;
    int lo_in;
    int lo_out;
    int step_out;
    int scale;
    r.value  = '0;
    r.status = adcapl_pkg::STATUS_OK;
    seg      = 0;
    scale    = 1 << adcapl_pkg::FRAC_BITS_DEF;
    // Under-range takes priority when both limits are violated.
    if (mean < int'(under_lim)) begin
      r.status = adcapl_pkg::STATUS_UNDER;
    end else if (mean > int'(over_lim)) begin
      r.status = adcapl_pkg::STATUS_OVER;
    end else begin
      // Segment search from the bottom; the index stops at the last segment.
      while (seg < adcapl_pkg::TABLE_POINTS - 2 &&
             int'(adcapl_pkg::BP_IN[seg+1]) < mean) seg++;
      lo_in    = int'(adcapl_pkg::BP_IN[seg]);
      lo_out   = int'(adcapl_pkg::BP_OUT[seg]);
      step_out = int'(adcapl_pkg::BP_OUT[seg+1]) - lo_out;
      den      = int'(adcapl_pkg::BP_IN[seg+1]) - lo_in;
      num      = step_out * scale * (mean - lo_in);
      if (den == 0) r.value = adcapl_pkg::VALUE_W'(lo_out * scale);
      else          r.value = adcapl_pkg::VALUE_W'(lo_out * scale + num / den);
    end
    return r;
  endfunction

  // Adds one accepted word to the group and queues a reading when it closes.
  function automatic void absorb_sample(input logic [adcapl_pkg::IN_TDATA_W-1:0] word);
    int mean;
    accum_sum = accum_sum + adcapl_pkg::SUM_W'(word[adcapl_pkg::SMP_W-1:0]);
    accum_count++;
    if (accum_count == adcapl_pkg::AVG_SAMPLES_DEF) begin
      mean        = int'(accum_sum) / adcapl_pkg::AVG_SAMPLES_DEF;
      accum_sum   = '0;
      accum_count = 0;
      pending_readings.push_back(convert_mean(mean));
    end
  endfunction

  task automatic report_mismatch(input string what, input int expected, input int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, expected, got);
    errors++;
  endtask

  // Result checker: every accepted word against the oldest prediction.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result word", 0, 1);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[adcapl_pkg::VALUE_W-1:0] !== want.value)
          report_mismatch("value", int'(want.value),
                          int'($signed(out_tdata[adcapl_pkg::VALUE_W-1:0])));
        if (out_tdata[adcapl_pkg::OUT_TDATA_W-1:adcapl_pkg::VALUE_W] !== '0)
          report_mismatch("tdata padding", 0,
                          int'(out_tdata[adcapl_pkg::OUT_TDATA_W-1:adcapl_pkg::VALUE_W]));
        if (out_tuser !== want.status)
          report_mismatch("status", int'(want.status), int'(out_tuser));
        case (want.status)
          adcapl_pkg::STATUS_UNDER: n_under++;
          adcapl_pkg::STATUS_OVER:  n_over++;
          default:                  n_ok++;
        endcase
      end
    end
  end

  // Sends one sample word, with random idle cycles ahead of it.
  task automatic send_sample(input logic [adcapl_pkg::IN_TDATA_W-1:0] word);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    samples_in++;
    absorb_sample(word);
  endtask

  task automatic send_constant_group(input logic [adcapl_pkg::IN_TDATA_W-1:0] word);
    for (int i = 0; i < adcapl_pkg::AVG_SAMPLES_DEF; i++) send_sample(word);
  endtask

  // Waits until every reading is out and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [adcapl_pkg::CFG_AW-1:0] addr,
                           input logic [adcapl_pkg::LIM_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (addr == adcapl_pkg::REG_UNDER_LIMIT) under_lim = data;
    else                                     over_lim  = data;
  endtask

  task automatic write_limits(input logic [adcapl_pkg::LIM_W-1:0] under,
                              input logic [adcapl_pkg::LIM_W-1:0] over);
    wait_idle();
    write_reg(adcapl_pkg::REG_UNDER_LIMIT, under);
    write_reg(adcapl_pkg::REG_OVER_LIMIT, over);
    n_settings++;
  endtask

  function automatic int clamp_sample(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // One random group: mostly clustered round a breakpoint or limit, some noise.
  task automatic send_random_group();
    int mode;
    int centre;
    int s;
    logic [3:0] pad;
    mode = $urandom_range(9);
    case ($urandom_range(3))
      0:       centre = int'(adcapl_pkg::BP_IN[$urandom_range(adcapl_pkg::TABLE_POINTS-1)]) +
                        $urandom_range(8) - 4;
      1:       centre = int'(under_lim) + $urandom_range(4) - 2;
      2:       centre = int'(over_lim) + $urandom_range(4) - 2;
      default: centre = $urandom_range(4095);
    endcase
    for (int i = 0; i < adcapl_pkg::AVG_SAMPLES_DEF; i++) begin
      if (mode < 2)       s = $urandom_range(4095);
      else if (mode == 2) s = clamp_sample(centre);
      else                s = clamp_sample(centre + $urandom_range(40) - 20);
      pad = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'h0;
      send_sample({pad, 12'(s)});
    end
  endtask

  // Full-scale samples, alternating bit patterns and junk in the pad bits.
  task automatic test_field_extremes();
    send_constant_group(16'h0000);
    send_constant_group(16'h0FFF);
    for (int i = 0; i < adcapl_pkg::AVG_SAMPLES_DEF; i++)
      send_sample((i % 2) ? 16'hFAAA : 16'h5555);
  endtask

  // Means sitting exactly on the reset limits are still in range.
  task automatic test_limit_edges();
    send_constant_group(16'(adcapl_pkg::UNDER_LIMIT_RST));
    send_constant_group(16'(adcapl_pkg::OVER_LIMIT_RST));
  endtask

  // Full-scale limits: both ends of the table are extrapolated.
  task automatic test_extrapolation();
    write_limits(12'd0, 12'd4095);
    send_constant_group(16'h0000);
    send_constant_group(16'h0FFF);
  endtask

  // Crossed limits: a mean violating both must report under-range.
  task automatic test_crossed_limits();
    write_limits(12'd4095, 12'd0);
    send_constant_group(16'd2000);
  endtask

  task automatic test_random_traffic(input int groups,
                                     input logic [adcapl_pkg::LIM_W-1:0] under,
                                     input logic [adcapl_pkg::LIM_W-1:0] over,
                                     input bit calm);
    write_limits(under, over);
    quiet = calm;
    for (int g = 0; g < groups; g++) send_random_group();
    wait_idle();
    quiet = 1'b0;
  endtask

  // Test sequence.
  initial begin
    logic [adcapl_pkg::LIM_W-1:0] lim_a;
    logic [adcapl_pkg::LIM_W-1:0] lim_b;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_field_extremes();
    test_limit_edges();
    test_extrapolation();
    test_crossed_limits();

    test_random_traffic(30, adcapl_pkg::UNDER_LIMIT_RST, adcapl_pkg::OVER_LIMIT_RST, 1'b0);
    test_random_traffic(20, 12'd0, 12'd4095, 1'b0);
    lim_a = 12'($urandom_range(1500));
    lim_b = 12'($urandom_range(4095, 2500));
    test_random_traffic(20, lim_a, lim_b, 1'b0);
    lim_a = 12'($urandom_range(700, 3700));
    test_random_traffic(10, lim_a, lim_a, 1'b0);
    lim_a = 12'($urandom_range(4095, 2000));
    lim_b = 12'($urandom_range(1999));
    test_random_traffic(10, lim_a, lim_b, 1'b0);
    test_random_traffic(20, adcapl_pkg::UNDER_LIMIT_RST, adcapl_pkg::OVER_LIMIT_RST, 1'b1);

    // Drain and let the pipeline settle.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) begin
      report_mismatch("readings left over", 0, pending_readings.size());
    end

    $display("Streamed %0d samples into %0d readings: %0d in range, %0d under, %0d over.",
             samples_in, n_ok + n_under + n_over, n_ok, n_under, n_over);
    $display("Covered %0d limit settings, including full-scale, crossed and equal pairs.",
             n_settings);
    if (errors == 0) begin
      $display("adc_average_piecewise_linearize_test: PASS");
    end else begin
      $display("%0d mismatches found", errors);
      $display("adc_average_piecewise_linearize_test: FAIL");
    end
    $finish;
  end

endmodule

// File: adc_average_piecewise_linearize.f
design/adcapl_pkg.sv
design/adcapl_sdiv.sv
design/adc_average_piecewise_linearize.sv
tb/adc_average_piecewise_linearize_test.sv
